/* design/cet_pkg.sv */
// ----------------------------------------------------------------------------
// Completion event tracker package
// Shared codes, the command word that passes from the front to the back, the
// table record and the result word.
// ----------------------------------------------------------------------------
package cet_pkg;

	// Request modes.
	localparam logic [1:0] MODE_ARM   = 2'd0;
	localparam logic [1:0] MODE_DATA  = 2'd1;
	localparam logic [1:0] MODE_UNSIG = 2'd2;
	localparam logic [1:0] MODE_TEST  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INTERNAL = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;
	localparam logic [1:0] ST_DROPPED  = 2'd3;

	// Entry kinds.
	localparam logic [1:0] KIND_UNUSED = 2'd0;
	localparam logic [1:0] KIND_SEND   = 2'd1;
	localparam logic [1:0] KIND_RECV   = 2'd2;

	// The work id carries one request index per byte.
	localparam int unsigned BYTES_PER_WID = 8;

	// Depth of the internal queues; must be a power of two.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Classified request as it travels from the front to the back.
	typedef struct packed {
		logic [1:0]               mode;
		logic [63:0]              work_id;
		logic [1:0]               dev_index;
		logic                     dev_ok;
		logic                     failed;
		logic                     with_immediate;
		logic [31:0]              imm_value;
		logic [7:0]               entry_index;
		logic                     eidx_ok;
		logic [BYTES_PER_WID-1:0] sub_ok;
		logic [1:0]               entry_kind;
		logic [3:0]               entry_batch;
		logic [7:0]               events_first;
		logic [7:0]               events_second;
		logic [31:0]              entry_size;
	} cmd_t;

	// One row of the request table.
	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  batch;
		logic [7:0]  ev0;
		logic [7:0]  ev1;
		logic        fail;
		logic [31:0] size;
	} rec_t;

	// One result word.
	typedef struct packed {
		logic [1:0]  status;
		logic        done_res;
		logic        result_failed;
		logic [31:0] size_out;
	} res_t;

	// Pick request index number j out of a work id.
	function automatic logic [7:0] wid_byte(logic [63:0] wid, logic [2:0] j);
		return wid[{j, 3'b000} +: 8];
	endfunction

endpackage

/* design/cet_fifo.sv */
// ----------------------------------------------------------------------------
// Small queue
// Register based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module cet_fifo #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import cet_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] data_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/cet_front.sv */
// ----------------------------------------------------------------------------
// Completion event tracker front
// Accepts request words, runs the range checks on every index and device,
// and queues the classified commands for the back.
// ----------------------------------------------------------------------------
module cet_front #(
	parameter int unsigned NUM_REQUESTS = 32,
	parameter int unsigned NUM_DEVS     = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    mode,
	input  logic [63:0]   work_id,
	input  logic [1:0]    dev_index,
	input  logic          failed,
	input  logic          with_immediate,
	input  logic [31:0]   imm_value,
	input  logic [7:0]    entry_index,
	input  logic [1:0]    entry_kind,
	input  logic [3:0]    entry_batch,
	input  logic [7:0]    events_first,
	input  logic [7:0]    events_second,
	input  logic [31:0]   entry_size,
	input  logic          cmd_pop,
	output cet_pkg::cmd_t cmd,
	output logic          cmd_empty
);
	import cet_pkg::*;

	cmd_t                     cmd_in;
	logic [BYTES_PER_WID-1:0] sub_ok;

	// Each byte of the work id is checked against the table size.
	always_comb begin
		for (int j = 0; j < BYTES_PER_WID; j++) begin
			sub_ok[j] = ({1'b0, wid_byte(work_id, 3'(j))} < 9'(NUM_REQUESTS));
		end
	end

	// Assemble the classified command.
	always_comb begin
		cmd_in.mode           = mode;
		cmd_in.work_id        = work_id;
		cmd_in.dev_index      = dev_index;
		cmd_in.dev_ok         = ({1'b0, dev_index} < 3'(NUM_DEVS));
		cmd_in.failed         = failed;
		cmd_in.with_immediate = with_immediate;
		cmd_in.imm_value      = imm_value;
		cmd_in.entry_index    = entry_index;
		cmd_in.eidx_ok        = ({1'b0, entry_index} < 9'(NUM_REQUESTS));
		cmd_in.sub_ok         = sub_ok;
		cmd_in.entry_kind     = entry_kind;
		cmd_in.entry_batch    = entry_batch;
		cmd_in.events_first   = events_first;
		cmd_in.events_second  = events_second;
		cmd_in.entry_size     = entry_size;
	end

	// Command queue toward the back.
	cet_fifo #(
		.WIDTH($bits(cmd_t))
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd),
		.empty (cmd_empty)
	);

endmodule

/* design/cet_back.sv */
// ----------------------------------------------------------------------------
// Completion event tracker back
// Holds the request table and carries out one command at a time, one table
// read-modify-write per cycle, and hands one result word per command.
// ----------------------------------------------------------------------------
module cet_back #(
	parameter int unsigned NUM_REQUESTS = 32,
	parameter int unsigned MAX_BATCH    = 8,
	parameter int unsigned NUM_DEVS     = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cet_pkg::cmd_t cmd,
	input  logic          cmd_empty,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output cet_pkg::res_t res_data
);
	import cet_pkg::*;

	localparam int unsigned IDX_W = $clog2(NUM_REQUESTS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_LOOK = 3'b010,
		S_STEP = 3'b100
	} state_t;

	state_t            state_q, state_d;
	cmd_t              cur_q, cur_d;
	logic [2:0]        j_q, j_d;
	logic [3:0]        batch_q, batch_d;

	rec_t              mem_q [NUM_REQUESTS];
	logic [NUM_REQUESTS-1:0] valid_q;
	rec_t              rd_q;
	logic              rd_valid_q;
	rec_t              rec;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	rec_t              mem_wd;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_ra;

	logic              take_ok;
	rec_t              take_rec;
	rec_t              base_rec;
	logic              size_upd;
	logic              base_ok;
	rec_t              base_taken;
	logic [2:0]        j_next;
	logic [7:0]        cur_byte;

	// Entries never armed read as the reset record.
	assign rec = rd_valid_q ? rd_q : '0;

	// Taking one event off the record that was just read.
	always_comb begin
		take_rec = rec;
		take_ok  = cur_q.dev_ok &&
			(cur_q.dev_index[0] ? (rec.ev1 != 8'd0) : (rec.ev0 != 8'd0));
		if (cur_q.dev_index[0]) begin
			take_rec.ev1 = rec.ev1 - 8'd1;
		end else begin
			take_rec.ev0 = rec.ev0 - 8'd1;
		end
		take_rec.fail = rec.fail | cur_q.failed;
	end

	// Single entry path: the size may be recorded before the event is taken.
	always_comb begin
		size_upd = !cur_q.failed && cur_q.with_immediate && (rec.batch == 4'd1);
		base_rec = rec;
		if (size_upd) begin
			base_rec.size = cur_q.imm_value;
		end
		base_taken = base_rec;
		base_ok    = take_ok;
		if (cur_q.dev_index[0]) begin
			base_taken.ev1 = base_rec.ev1 - 8'd1;
		end else begin
			base_taken.ev0 = base_rec.ev0 - 8'd1;
		end
		base_taken.fail = base_rec.fail | cur_q.failed;
	end

	assign j_next   = j_q + 3'd1;
	assign cur_byte = wid_byte(cur_q.work_id, j_q);

	// Sequencer.
	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		j_d      = j_q;
		batch_d  = batch_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_data = '0;
		mem_we   = 1'b0;
		mem_wa   = '0;
		mem_wd   = rec;
		mem_re   = 1'b0;
		mem_ra   = '0;
		case (state_q)
			S_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					cur_d   = cmd;
					case (cmd.mode)
						MODE_ARM: begin
							res_push = 1'b1;
							if (!cmd.eidx_ok) begin
								res_data.status = ST_INVALID;
							end else begin
								mem_we       = 1'b1;
								mem_wa       = cmd.entry_index[IDX_W-1:0];
								mem_wd.kind  = cmd.entry_kind;
								mem_wd.batch = cmd.entry_batch;
								mem_wd.ev0   = cmd.events_first;
								mem_wd.ev1   = cmd.events_second;
								mem_wd.fail  = 1'b0;
								mem_wd.size  = cmd.entry_size;
							end
						end
						MODE_TEST: begin
							if (!cmd.eidx_ok) begin
								res_push        = 1'b1;
								res_data.status = ST_INVALID;
							end else begin
								mem_re  = 1'b1;
								mem_ra  = cmd.entry_index[IDX_W-1:0];
								state_d = S_LOOK;
							end
						end
						MODE_DATA: begin
							if (!cmd.sub_ok[0]) begin
								res_push        = 1'b1;
								res_data.status = cmd.failed ? ST_INTERNAL : ST_DROPPED;
							end else begin
								mem_re  = 1'b1;
								mem_ra  = cmd.work_id[IDX_W-1:0];
								state_d = S_LOOK;
							end
						end
						MODE_UNSIG: begin
							if (!cmd.sub_ok[0]) begin
								res_push        = 1'b1;
								res_data.status = ST_INTERNAL;
							end else begin
								mem_re  = 1'b1;
								mem_ra  = cmd.work_id[IDX_W-1:0];
								state_d = S_LOOK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_LOOK: begin
				state_d  = S_IDLE;
				res_push = 1'b1;
				case (cur_q.mode)
					MODE_TEST: begin
						mem_wa = cur_q.entry_index[IDX_W-1:0];
						if ((rec.ev0 == 8'd0) && ((NUM_DEVS < 2) || (rec.ev1 == 8'd0))) begin
							res_data.done_res      = 1'b1;
							res_data.result_failed = rec.fail;
							res_data.size_out      =
								(rec.kind inside {KIND_SEND, KIND_RECV}) ? rec.size : 32'd0;
							mem_we      = 1'b1;
							mem_wd.kind = KIND_UNUSED;
						end
					end
					MODE_UNSIG: begin
						mem_wa = cur_q.work_id[IDX_W-1:0];
						if (rec.kind == KIND_UNUSED) begin
							res_data.status = ST_INTERNAL;
						end else if (cur_q.failed) begin
							mem_we      = 1'b1;
							mem_wd.fail = 1'b1;
						end
					end
					MODE_DATA: begin
						mem_wa = cur_q.work_id[IDX_W-1:0];
						if (!cur_q.failed && cur_q.with_immediate &&
							rec.kind != KIND_SEND && rec.kind != KIND_RECV) begin
							// Immediate data on an entry that cannot receive.
							res_data.status = ST_DROPPED;
						end else if (rec.kind == KIND_UNUSED) begin
							res_data.status = ST_INTERNAL;
						end else if (rec.kind != KIND_SEND) begin
							// Single entry: the recorded size stands even if the event fails.
							mem_we          = base_ok || size_upd;
							mem_wd          = base_ok ? base_taken : base_rec;
							res_data.status = base_ok ? ST_OK : ST_INTERNAL;
						end else if (rec.batch == 4'd0 || rec.batch > 4'(MAX_BATCH)) begin
							res_data.status = ST_INTERNAL;
						end else if (!take_ok) begin
							res_data.status = ST_INTERNAL;
						end else begin
							// First batched entry is the head entry itself.
							mem_we = 1'b1;
							mem_wd = take_rec;
							if (rec.batch == 4'd1) begin
								res_data.status = ST_OK;
							end else if (!cur_q.sub_ok[1]) begin
								res_data.status = ST_INTERNAL;
							end else begin
								res_push = 1'b0;
								mem_re   = 1'b1;
								mem_ra   = cur_q.work_id[8 +: IDX_W];
								j_d      = 3'd1;
								batch_d  = rec.batch;
								state_d  = S_STEP;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_STEP: begin
				mem_wa = cur_byte[IDX_W-1:0];
				if (!take_ok) begin
					res_push        = 1'b1;
					res_data.status = ST_INTERNAL;
					state_d         = S_IDLE;
				end else begin
					mem_we = 1'b1;
					mem_wd = take_rec;
					if (({1'b0, j_q} + 4'd1) == batch_q) begin
						res_push        = 1'b1;
						res_data.status = ST_OK;
						state_d         = S_IDLE;
					end else if (!cur_q.sub_ok[j_next]) begin
						res_push        = 1'b1;
						res_data.status = ST_INTERNAL;
						state_d         = S_IDLE;
					end else begin
						mem_re = 1'b1;
						mem_ra = cur_q.work_id[{j_next, 3'b000} +: IDX_W];
						j_d    = j_next;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Request table with a write-to-read bypass for back-to-back entries.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= (mem_we && mem_wa == mem_ra) ? mem_wd : mem_q[mem_ra];
		end
	end

	// Written marks for the table rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[mem_wa] <= 1'b1;
			end
			if (mem_re) begin
				rd_valid_q <= (mem_we && mem_wa == mem_ra) || valid_q[mem_ra];
			end
		end
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			batch_q <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			batch_q <= batch_d;
		end
	end

	// Current command holds payload only.
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
	end

endmodule

/* design/rdma_completion_event_tracker.sv */
// ----------------------------------------------------------------------------
// Completion event tracker
// Tracks outstanding transfer requests: arm, data completion, unsignaled
// completion and test, each answered by one result word.
//
// Usage: request words enter through push/full; a word is taken on a clock
// edge with push high and full low. Results leave in order through
// empty/pop; the oldest word sits on the result ports while empty is low and
// is taken on an edge with pop high. Two-word queues sit on both sides, so
// the input keeps accepting while results wait to be taken.
// Sequence: arm and requests whose first index is out of range finish in the
// back's idle state; test, unsignaled and single-entry completions go on to a
// table lookup; a batched send then steps through the rest of its batch (up to
// eight entries), one table read-modify-write per batched entry.
// Reset clears the queues and marks every table row as never armed, so it
// reads as unused with zero counts; no clearing pass is needed.
// When the result queue is full the back holds its next command; once the
// command queue fills too, full rises and holds off the sender.
// ----------------------------------------------------------------------------
module rdma_completion_event_tracker #(
	parameter int unsigned NUM_REQUESTS = 32,
	parameter int unsigned MAX_BATCH    = 8,
	parameter int unsigned NUM_DEVS     = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [63:0] work_id,
	input  logic [1:0]  dev_index,
	input  logic        failed,
	input  logic        with_immediate,
	input  logic [31:0] imm_value,
	input  logic [7:0]  entry_index,
	input  logic [1:0]  entry_kind,
	input  logic [3:0]  entry_batch,
	input  logic [7:0]  events_first,
	input  logic [7:0]  events_second,
	input  logic [31:0] entry_size,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic        done_res,
	output logic        result_failed,
	output logic [31:0] size_out
);
	import cet_pkg::*;

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;
	logic res_full;
	logic res_push;
	res_t res_in;
	res_t res_out;

	// Front: checks and command queue.
	cet_front #(
		.NUM_REQUESTS(NUM_REQUESTS),
		.NUM_DEVS    (NUM_DEVS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.mode          (mode),
		.work_id       (work_id),
		.dev_index     (dev_index),
		.failed        (failed),
		.with_immediate(with_immediate),
		.imm_value     (imm_value),
		.entry_index   (entry_index),
		.entry_kind    (entry_kind),
		.entry_batch   (entry_batch),
		.events_first  (events_first),
		.events_second (events_second),
		.entry_size    (entry_size),
		.cmd_pop       (cmd_pop),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty)
	);

	// Back: request table and sequencer.
	cet_back #(
		.NUM_REQUESTS(NUM_REQUESTS),
		.MAX_BATCH   (MAX_BATCH),
		.NUM_DEVS    (NUM_DEVS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_in)
	);

	// Result queue toward the receiver.
	cet_fifo #(
		.WIDTH($bits(res_t))
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign status        = res_out.status;
	assign done_res      = res_out.done_res;
	assign result_failed = res_out.result_failed;
	assign size_out      = res_out.size_out;

endmodule
